FILE: src/fkg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fkg_pkg: shared types and constants for the greedy fractional knapsack.
// Holds field widths, controller states and the command and status bundles.
// ----------------------------------------------------------------------------
package fkg_pkg;

    localparam int MAX_ITEMS_DEF = 64;
    localparam int VALUE_W       = 16;
    localparam int WEIGHT_W      = 16;
    localparam int CAP_W         = 32;
    localparam int TOTAL_W       = 22;
    localparam int PROD_W        = VALUE_W + WEIGHT_W;

    typedef enum logic [2:0] {
        S_LOAD,
        S_SCAN,
        S_FILL,
        S_DIV,
        S_OUT
    } t_state;

    typedef struct packed {
        logic load;       // store the item on the input channel
        logic fill_init;  // start a new set: load capacity, clear total
        logic scan_init;  // restart the density scan
        logic scan_run;   // advance the density scan
        logic take;       // add the selected item whole
        logic div_start;  // start the partial item division
        logic div_run;    // one quotient bit
        logic div_add;    // add the quotient to the total
        logic publish;    // move the total into the output register
    } t_dp_cmd;

    typedef struct packed {
        logic scan_done;
        logic found;
        logic fits;
        logic div_done;
        logic out_free;
    } t_dp_sts;

    // Adds a value to the running total, holding at the largest code.
    function automatic logic [TOTAL_W-1:0] sat_add(input logic [TOTAL_W-1:0] a,
                                                   input logic [VALUE_W-1:0] b);
        logic [TOTAL_W:0] s;
        s = {1'b0, a} + {{(TOTAL_W + 1 - VALUE_W){1'b0}}, b};
        return s[TOTAL_W] ? {TOTAL_W{1'b1}} : s[TOTAL_W-1:0];
    endfunction

endpackage

FILE: src/fractional_knapsack_greedy_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fractional_knapsack_greedy_top: greedy fractional knapsack over a set of items.
// Loads value and weight pairs, ranks by density and fills the capacity.
// ----------------------------------------------------------------------------
// Items transfer one per cycle while the block is loading; a zero weight is
// stored as one. The transfer flagged as the last item closes the set, and the
// block then drops ready while it ranks and fills. Ranking is done by repeated
// scans of the item stores: each scan reads one stored item per cycle and keeps
// the densest item that ranks after the one taken before, comparing exact
// cross products, with ties going to the earlier item. A set of n items takes
// up to n + 1 scans, each followed by a fill step, and the first item that
// does not fit adds a 32-step bit-serial division of remaining capacity times
// value by weight. The total is then moved into the result register. Items
// beyond MAX_ITEMS are dropped and reported in o_items_dropped. The result
// sits in an output register and is offered until its transfer; loading of the
// next set waits until the result register is free. A capacity write takes
// effect when the next set is closed by its last item after the write.
// ----------------------------------------------------------------------------
module fractional_knapsack_greedy_top #(
    parameter int MAX_ITEMS = fkg_pkg::MAX_ITEMS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [fkg_pkg::CAP_W-1:0]    i_cfg_wdata,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [fkg_pkg::VALUE_W-1:0]  i_item_value,
    input  logic [fkg_pkg::WEIGHT_W-1:0] i_item_weight,
    input  logic                         i_last_item,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [fkg_pkg::TOTAL_W-1:0]  o_max_value,
    output logic                         o_items_dropped
);

    fkg_pkg::t_dp_cmd cmd;
    fkg_pkg::t_dp_sts sts;

    // The controller only sequences; all storage and arithmetic is in the datapath.
    fkg_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_last_item (i_last_item),
        .i_sts       (sts),
        .o_ready     (o_ready),
        .o_cmd       (cmd)
    );

    fkg_dp #(
        .MAX_ITEMS (MAX_ITEMS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_item_value    (i_item_value),
        .i_item_weight   (i_item_weight),
        .i_cmd           (cmd),
        .i_ready         (i_ready),
        .o_sts           (sts),
        .o_valid         (o_valid),
        .o_max_value     (o_max_value),
        .o_items_dropped (o_items_dropped)
    );

endmodule

FILE: src/fkg_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fkg_ctrl: sequencing state machine.
// Steps through load, density scan, fill, division and result hand-off.
// ----------------------------------------------------------------------------
module fkg_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic            i_last_item,
    input  fkg_pkg::t_dp_sts i_sts,
    output logic            o_ready,
    output fkg_pkg::t_dp_cmd o_cmd
);

    fkg_pkg::t_state r_state;
    fkg_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fkg_pkg::S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        case (r_state)
            fkg_pkg::S_LOAD: begin
                o_ready   = 1'b1;
                o_cmd.load = i_valid;
                if (i_valid && i_last_item) begin
                    o_cmd.fill_init = 1'b1;
                    o_cmd.scan_init = 1'b1;
                    n_state         = fkg_pkg::S_SCAN;
                end
            end
            fkg_pkg::S_SCAN: begin
                o_cmd.scan_run = 1'b1;
                if (i_sts.scan_done) begin
                    n_state = fkg_pkg::S_FILL;
                end
            end
            fkg_pkg::S_FILL: begin
                if (!i_sts.found) begin
                    n_state = fkg_pkg::S_OUT;
                end else if (i_sts.fits) begin
                    o_cmd.take      = 1'b1;
                    o_cmd.scan_init = 1'b1;
                    n_state         = fkg_pkg::S_SCAN;
                end else begin
                    o_cmd.div_start = 1'b1;
                    n_state         = fkg_pkg::S_DIV;
                end
            end
            fkg_pkg::S_DIV: begin
                if (i_sts.div_done) begin
                    o_cmd.div_add = 1'b1;
                    n_state       = fkg_pkg::S_OUT;
                end else begin
                    o_cmd.div_run = 1'b1;
                end
            end
            fkg_pkg::S_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.publish = 1'b1;
                    n_state       = fkg_pkg::S_LOAD;
                end
            end
            default: begin
                n_state = fkg_pkg::S_LOAD;
            end
        endcase
    end

endmodule

FILE: src/fkg_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fkg_dp: item stores, density scan, greedy fill and bit-serial divider.
// Each scan finds the densest item ranked after the one taken last.
// ----------------------------------------------------------------------------
module fkg_dp #(
    parameter int MAX_ITEMS = fkg_pkg::MAX_ITEMS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [fkg_pkg::CAP_W-1:0]    i_cfg_wdata,
    input  logic [fkg_pkg::VALUE_W-1:0]  i_item_value,
    input  logic [fkg_pkg::WEIGHT_W-1:0] i_item_weight,
    input  fkg_pkg::t_dp_cmd             i_cmd,
    input  logic                         i_ready,
    output fkg_pkg::t_dp_sts             o_sts,
    output logic                         o_valid,
    output logic [fkg_pkg::TOTAL_W-1:0]  o_max_value,
    output logic                         o_items_dropped
);

    localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int CW = $clog2(MAX_ITEMS + 1);
    localparam int VW = fkg_pkg::VALUE_W;
    localparam int WW = fkg_pkg::WEIGHT_W;
    localparam int PW = fkg_pkg::PROD_W;
    localparam int DCW = $clog2(PW + 1);
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_ITEMS);

    logic [VW-1:0] r_vmem [MAX_ITEMS];
    logic [WW-1:0] r_wmem [MAX_ITEMS];

    logic [fkg_pkg::CAP_W-1:0]   r_capacity;
    logic [CW-1:0]               r_count;
    logic                        r_ovf;
    logic [fkg_pkg::CAP_W-1:0]   r_left;
    logic [fkg_pkg::TOTAL_W-1:0] r_total;
    logic [CW-1:0]               r_addr;
    logic                        r_rd_vld;
    logic [AW-1:0]               r_rd_idx;
    logic [VW-1:0]               r_rv;
    logic [WW-1:0]               r_rw;
    logic                        r_found;
    logic [VW-1:0]               r_bv;
    logic [WW-1:0]               r_bw;
    logic [AW-1:0]               r_bidx;
    logic                        r_have_prev;
    logic [VW-1:0]               r_pv;
    logic [WW-1:0]               r_pw;
    logic [AW-1:0]               r_pidx;
    logic [PW-1:0]               r_quo;
    logic [WW-1:0]               r_rem;
    logic [DCW-1:0]              r_dcnt;
    logic                        r_out_valid;
    logic [fkg_pkg::TOTAL_W-1:0] r_out_value;
    logic                        r_out_drop;

    logic [WW-1:0] wr_weight;
    logic [PW-1:0] c_lhs_p;
    logic [PW-1:0] c_rhs_p;
    logic [PW-1:0] c_lhs_b;
    logic [PW-1:0] c_rhs_b;
    logic          eligible;
    logic          better;
    logic [WW:0]   div_trial;
    logic          div_bit;

    assign wr_weight = (i_item_weight == '0) ? WW'(1) : i_item_weight;

    // Candidate ranks after the previous pick: lower density, or equal and later.
    assign c_lhs_p  = r_rv * r_pw;
    assign c_rhs_p  = r_pv * r_rw;
    assign eligible = !r_have_prev || (c_lhs_p < c_rhs_p)
                      || ((c_lhs_p == c_rhs_p) && (r_rd_idx > r_pidx));
    assign c_lhs_b  = r_rv * r_bw;
    assign c_rhs_b  = r_bv * r_rw;
    assign better   = !r_found || (c_lhs_b > c_rhs_b);

    assign div_trial = {r_rem, r_quo[PW-1]};
    assign div_bit   = (div_trial >= {1'b0, r_bw});

    always_ff @(posedge i_clk) begin
        if (i_cmd.load && (r_count < MAX_CNT)) begin
            r_vmem[r_count[AW-1:0]] <= i_item_value;
            r_wmem[r_count[AW-1:0]] <= wr_weight;
        end
        if (i_cmd.scan_run && (r_addr < r_count)) begin
            r_rv     <= r_vmem[r_addr[AW-1:0]];
            r_rw     <= r_wmem[r_addr[AW-1:0]];
            r_rd_idx <= r_addr[AW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity  <= '0;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_addr      <= '0;
            r_rd_vld    <= 1'b0;
            r_found     <= 1'b0;
            r_have_prev <= 1'b0;
            r_dcnt      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_capacity <= i_cfg_wdata;
            end
            if (i_cmd.load) begin
                if (r_count < MAX_CNT) begin
                    r_count <= r_count + CW'(1);
                end else begin
                    r_ovf <= 1'b1;
                end
            end
            if (i_cmd.fill_init) begin
                r_have_prev <= 1'b0;
            end else if (i_cmd.take) begin
                r_have_prev <= 1'b1;
            end
            if (i_cmd.scan_init) begin
                r_addr   <= '0;
                r_rd_vld <= 1'b0;
                r_found  <= 1'b0;
            end else if (i_cmd.scan_run) begin
                r_rd_vld <= (r_addr < r_count);
                if (r_addr < r_count) begin
                    r_addr <= r_addr + CW'(1);
                end
                if (r_rd_vld && eligible && better) begin
                    r_found <= 1'b1;
                end
            end else if (i_cmd.publish) begin
                // The set is closed, so the scan pointer starts over with it.
                r_addr <= '0;
            end
            if (i_cmd.div_start) begin
                r_dcnt <= DCW'(PW);
            end else if (i_cmd.div_run) begin
                r_dcnt <= r_dcnt - DCW'(1);
            end
            if (i_cmd.publish) begin
                r_out_valid <= 1'b1;
                r_count     <= '0;
                r_ovf       <= 1'b0;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.fill_init) begin
            r_left  <= r_capacity;
            r_total <= '0;
        end else if (i_cmd.take) begin
            r_left  <= r_left - {{(fkg_pkg::CAP_W - WW){1'b0}}, r_bw};
            r_total <= fkg_pkg::sat_add(r_total, r_bv);
        end else if (i_cmd.div_add) begin
            r_total <= fkg_pkg::sat_add(r_total, r_quo[VW-1:0]);
        end
        if (i_cmd.take) begin
            r_pv   <= r_bv;
            r_pw   <= r_bw;
            r_pidx <= r_bidx;
        end
        if (i_cmd.scan_run && r_rd_vld && eligible && better) begin
            r_bv   <= r_rv;
            r_bw   <= r_rw;
            r_bidx <= r_rd_idx;
        end
        // The remaining capacity is below the weight here, so it fits in WW bits.
        if (i_cmd.div_start) begin
            r_quo <= r_left[WW-1:0] * r_bv;
            r_rem <= '0;
        end else if (i_cmd.div_run) begin
            r_quo <= {r_quo[PW-2:0], div_bit};
            r_rem <= div_bit ? WW'(div_trial - {1'b0, r_bw}) : div_trial[WW-1:0];
        end
        if (i_cmd.publish) begin
            r_out_value <= r_total;
            r_out_drop  <= r_ovf;
        end
    end

    assign o_sts.scan_done = (r_addr == r_count) && !r_rd_vld;
    assign o_sts.found     = r_found;
    assign o_sts.fits      = ({{(fkg_pkg::CAP_W - WW){1'b0}}, r_bw} <= r_left);
    assign o_sts.div_done  = (r_dcnt == '0);
    assign o_sts.out_free  = !r_out_valid || i_ready;

    assign o_valid         = r_out_valid;
    assign o_max_value     = r_out_value;
    assign o_items_dropped = r_out_drop;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= MAX_CNT)
        else $error("item count exceeds the store depth");

    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_addr <= r_count)
        else $error("scan address ran past the stored items");

    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_run |=> (r_rem < r_bw))
        else $error("division remainder not below the divisor");

    a_take_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.take |-> (r_found && o_sts.fits))
        else $error("whole item taken without room for it");

endmodule
